// File: hdl/tpq_pkg.sv
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types, widths and codes for the tree path min/max query block.
// ----------------------------------------------------------------------------
package tpq_pkg;

	localparam int NODE_COUNT  = 1024;
	localparam int LIFT_LEVELS = 10;
	localparam int WEIGHT_BITS = 20;
	localparam int NODE_BITS   = $clog2(NODE_COUNT);
	localparam int LVL_BITS    = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
	localparam int JADDR_DEPTH = NODE_COUNT * LIFT_LEVELS;
	localparam int JADDR_BITS  = $clog2(JADDR_DEPTH);
	// jump entry: valid, ancestor, min, max
	localparam int JUMP_BITS   = 1 + NODE_BITS + 2 * WEIGHT_BITS;
	// depth entry: attached flag, depth
	localparam int DREC_BITS   = 1 + NODE_BITS;
	localparam logic [NODE_BITS-1:0] DEPTH_MAX = NODE_BITS'(NODE_COUNT - 1);
	localparam logic [LVL_BITS-1:0]  LVL_TOP   = LVL_BITS'(LIFT_LEVELS - 1);

	localparam logic REQ_ATTACH = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;
	localparam logic ST_OK      = 1'b0;
	localparam logic ST_ERR     = 1'b1;

	typedef struct packed {
		logic                   ok;
		logic [NODE_BITS-1:0]   anc;
		logic [WEIGHT_BITS-1:0] mn;
		logic [WEIGHT_BITS-1:0] mx;
	} jump_t;

	typedef struct packed {
		logic                 att;
		logic [NODE_BITS-1:0] dep;
	} drec_t;

	typedef enum logic [4:0] {
		S_CLR,       // clear depth memory after reset
		S_IDLE,
		S_A_RD,      // read parent attached/depth
		S_A_CHK,
		S_A_LRD,     // read ancestor jump at level-1
		S_A_LWR,
		S_Q_RD,      // read attached/depth of both
		S_Q_CHK,
		S_L1_RD,     // read jump of v at level
		S_L1_DRD,    // read depth of target
		S_L1_UPD,
		S_EQ_CHK,
		S_L2_RDU,
		S_L2_RDV,
		S_L2_UPD,
		S_FIN_RDU,
		S_FIN_RDV,
		S_FIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic a_rd;
		logic a_root;
		logic a_wr0;
		logic a_lrd;
		logic a_lwr;
		logic q_rd;
		logic q_swap;
		logic l1_rd;
		logic l1_drd;
		logic l1_upd;
		logic l2_rdu;
		logic l2_rdv;
		logic l2_upd;
		logic fin;
		logic set_err;
		logic set_empty;
		logic set_ok_path;
		logic lvl_init;
		logic lvl_dec;
		logic out_load;
	} ctl_t;

	typedef struct packed {
		logic clr_done;
		logic req_query;
		logic a_bad_node;
		logic a_is_root;
		logic p_missing;
		logic q_missing;
		logic q_same;
		logic lvl_zero;
		logic lvl_last;
		logic meet;
		logic depth_ne;
		logic l2_err;
		logic fin_err;
	} sts_t;

endpackage

// File: hdl/tpq_ram.sv
// ----------------------------------------------------------------------------
// tpq_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module tpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// File: hdl/tpq_ctrl.sv
// ----------------------------------------------------------------------------
// tpq_ctrl
// Sequencer for attach fills and two-pass path lifting.
// ----------------------------------------------------------------------------
module tpq_ctrl import tpq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic out_free,
	input  sts_t sts,
	output ctl_t ctl
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR:     if (sts.clr_done) state_d = S_IDLE;
			S_IDLE:    if (in_valid) state_d = sts.req_query ? S_Q_RD : S_A_RD;
			S_A_RD:    state_d = S_A_CHK;
			S_A_CHK: begin
				priority if (sts.a_bad_node || (!sts.a_is_root && sts.p_missing))
					state_d = S_OUT;
				else if (LIFT_LEVELS == 1) state_d = S_OUT;
				else state_d = S_A_LRD;
			end
			S_A_LRD:   state_d = S_A_LWR;
			S_A_LWR:   state_d = sts.lvl_last ? S_OUT : S_A_LRD;
			S_Q_RD:    state_d = S_Q_CHK;
			S_Q_CHK:   state_d = (sts.q_missing || sts.q_same) ? S_OUT : S_L1_RD;
			S_L1_RD:   state_d = S_L1_DRD;
			S_L1_DRD:  state_d = S_L1_UPD;
			S_L1_UPD:  state_d = sts.lvl_zero ? S_EQ_CHK : S_L1_RD;
			S_EQ_CHK: begin
				priority if (sts.meet) state_d = S_OUT;
				else if (sts.depth_ne) state_d = S_OUT;
				else state_d = S_L2_RDU;
			end
			S_L2_RDU:  state_d = S_L2_RDV;
			S_L2_RDV:  state_d = S_L2_UPD;
			S_L2_UPD: begin
				priority if (sts.l2_err) state_d = S_OUT;
				else if (sts.lvl_zero) state_d = S_FIN_RDU;
				else state_d = S_L2_RDU;
			end
			S_FIN_RDU: state_d = S_FIN_RDV;
			S_FIN_RDV: state_d = S_FIN;
			S_FIN:     state_d = S_OUT;
			S_OUT:     if (out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_CLR:     ctl.clr = 1'b1;
			S_IDLE:    ctl.load = in_valid;
			S_A_RD:    ctl.a_rd = 1'b1;
			S_A_CHK: begin
				priority if (sts.a_bad_node) ctl.set_err = 1'b1;
				else if (sts.a_is_root) ctl.a_root = 1'b1;
				else if (sts.p_missing) ctl.set_err = 1'b1;
				else ctl.a_wr0 = 1'b1;
			end
			S_A_LRD:   ctl.a_lrd = 1'b1;
			S_A_LWR:   ctl.a_lwr = 1'b1;
			S_Q_RD:    ctl.q_rd = 1'b1;
			S_Q_CHK: begin
				priority if (sts.q_missing) ctl.set_err = 1'b1;
				else if (sts.q_same) ctl.set_empty = 1'b1;
				else begin
					ctl.q_swap = 1'b1;
					ctl.lvl_init = 1'b1;
				end
			end
			S_L1_RD:   ctl.l1_rd = 1'b1;
			S_L1_DRD:  ctl.l1_drd = 1'b1;
			S_L1_UPD: begin
				ctl.l1_upd = 1'b1;
				ctl.lvl_dec = 1'b1;
				ctl.lvl_init = sts.lvl_zero;
			end
			S_EQ_CHK: begin
				priority if (sts.meet) ctl.set_ok_path = 1'b1;
				else if (sts.depth_ne) ctl.set_err = 1'b1;
			end
			S_L2_RDU:  ctl.l2_rdu = 1'b1;
			S_L2_RDV:  ctl.l2_rdv = 1'b1;
			S_L2_UPD: begin
				ctl.l2_upd = 1'b1;
				ctl.lvl_dec = !sts.lvl_zero;
				ctl.set_err = sts.l2_err;
			end
			S_FIN_RDU: ctl.l2_rdu = 1'b1;
			S_FIN_RDV: ctl.l2_rdv = 1'b1;
			S_FIN: begin
				ctl.fin = 1'b1;
				if (sts.fin_err) ctl.set_err = 1'b1;
				else ctl.set_ok_path = 1'b1;
			end
			S_OUT:     ctl.out_load = out_free;
			default:   ctl = '0;
		endcase
	end
endmodule

// File: hdl/tpq_dp.sv
// ----------------------------------------------------------------------------
// tpq_dp
// Tree tables, lifting registers and min/max accumulation.
// ----------------------------------------------------------------------------
module tpq_dp import tpq_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctl_t                   ctl,
	output sts_t                   sts,
	input  logic                   req_type,
	input  logic [9:0]             node,
	input  logic [9:0]             other_node,
	input  logic [19:0]            weight,
	output logic                   r_status,
	output logic [19:0]            r_min,
	output logic [19:0]            r_max,
	output logic                   r_empty
);
	logic                   type_q;
	logic [NODE_BITS-1:0]   u_q, v_q;
	logic [WEIGHT_BITS-1:0] w_q, lo_q, hi_q;
	logic                   u_inr_q, v_inr_q;
	logic [LVL_BITS-1:0]    lvl_q;
	logic                   err_q, empty_q, path_q;
	logic                   ua_q, va_q;
	logic [NODE_BITS-1:0]   clr_q;
	logic [NODE_BITS-1:0]   du_q, dv_q;
	jump_t                  prev_q, ju_q;

	// depth ram, two ports emulated by two copies
	logic                   d_we;
	logic [NODE_BITS-1:0]   d_addr_a, d_addr_b;
	drec_t                  d_wdata, d_rd_a, d_rd_b;
	logic                   j_we;
	logic [JADDR_BITS-1:0]  j_addr;
	jump_t                  j_wdata, j_rd;

	tpq_ram #(.WIDTH(DREC_BITS), .DEPTH(NODE_COUNT)) u_depth_a (
		.clk(clk), .we(d_we), .addr(d_addr_a), .wdata(d_wdata), .rdata(d_rd_a));
	tpq_ram #(.WIDTH(DREC_BITS), .DEPTH(NODE_COUNT)) u_depth_b (
		.clk(clk), .we(d_we), .addr(d_addr_b), .wdata(d_wdata), .rdata(d_rd_b));
	tpq_ram #(.WIDTH(JUMP_BITS), .DEPTH(JADDR_DEPTH)) u_jump (
		.clk(clk), .we(j_we), .addr(j_addr), .wdata(j_wdata), .rdata(j_rd));

	function automatic logic [JADDR_BITS-1:0] jidx(logic [NODE_BITS-1:0] n,
		logic [LVL_BITS-1:0] l);
		logic [JADDR_BITS+LVL_BITS-1:0] t;
		t = (JADDR_BITS+LVL_BITS)'(n) * (JADDR_BITS+LVL_BITS)'(LIFT_LEVELS)
			+ (JADDR_BITS+LVL_BITS)'(l);
		return t[JADDR_BITS-1:0];
	endfunction

	function automatic logic [WEIGHT_BITS-1:0] wmin(logic [WEIGHT_BITS-1:0] a,
		logic [WEIGHT_BITS-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [WEIGHT_BITS-1:0] wmax(logic [WEIGHT_BITS-1:0] a,
		logic [WEIGHT_BITS-1:0] b);
		return (a > b) ? a : b;
	endfunction

	logic [LVL_BITS-1:0] lvl_m1;
	assign lvl_m1 = lvl_q - LVL_BITS'(1);

	// address and write selection
	always_comb begin
		d_we     = 1'b0;
		d_wdata  = '0;
		d_addr_a = u_q;
		d_addr_b = v_q;
		j_we     = 1'b0;
		j_addr   = jidx(v_q, lvl_q);
		j_wdata  = prev_q;
		if (ctl.clr) begin
			d_we     = 1'b1;
			d_addr_a = clr_q;
			d_addr_b = clr_q;
			d_wdata  = '0;
		end else if (ctl.load) begin
			d_addr_a = NODE_BITS'(node);
			d_addr_b = NODE_BITS'(other_node);
		end else if (ctl.a_root) begin
			d_we    = 1'b1;
			d_addr_a = u_q;
			d_addr_b = u_q;
			d_wdata = '{att: 1'b1, dep: '0};
		end else if (ctl.a_wr0) begin
			d_we     = 1'b1;
			d_addr_a = u_q;
			d_addr_b = u_q;
			d_wdata  = '{att: 1'b1,
				dep: (dv_q >= DEPTH_MAX) ? DEPTH_MAX : dv_q + NODE_BITS'(1)};
		end
		if (ctl.a_wr0) begin
			j_we    = 1'b1;
			j_addr  = jidx(u_q, '0);
			j_wdata = '{ok: 1'b1, anc: v_q, mn: w_q, mx: w_q};
		end else if (ctl.a_root) begin
			j_we    = 1'b1;
			j_addr  = jidx(u_q, '0);
			j_wdata = '0;
		end else if (ctl.a_lrd) begin
			j_addr = jidx(prev_q.anc, lvl_m1);
		end else if (ctl.a_lwr) begin
			j_we   = 1'b1;
			j_addr = jidx(u_q, lvl_q);
			if (prev_q.ok)
				j_wdata = '{ok: j_rd.ok, anc: j_rd.ok ? j_rd.anc : '0,
					mn: wmin(prev_q.mn, j_rd.mn), mx: wmax(prev_q.mx, j_rd.mx)};
			else
				j_wdata = '{ok: 1'b0, anc: '0, mn: prev_q.mn, mx: prev_q.mx};
		end else if (ctl.l1_rd) begin
			j_addr = jidx(v_q, lvl_q);
		end else if (ctl.l2_rdu) begin
			j_addr = jidx(u_q, lvl_q);
		end else if (ctl.l2_rdv) begin
			j_addr = jidx(v_q, lvl_q);
		end
		if (ctl.l1_drd) d_addr_b = j_rd.anc;
	end

	logic l2_diff;
	assign l2_diff = (ju_q.ok != j_rd.ok) || (j_rd.ok && ju_q.anc != j_rd.anc);

	always_comb begin
		sts.clr_done   = (clr_q == DEPTH_MAX);
		sts.req_query  = (req_type == REQ_QUERY);
		sts.a_bad_node = !u_inr_q;
		sts.a_is_root  = (u_q == v_q);
		sts.p_missing  = !(v_inr_q && va_q);
		sts.q_missing  = !(u_inr_q && ua_q) || !(v_inr_q && va_q);
		sts.q_same     = (u_q == v_q);
		sts.lvl_zero   = (lvl_q == '0);
		sts.lvl_last   = (lvl_q == LVL_TOP);
		sts.meet       = (u_q == v_q);
		sts.depth_ne   = (du_q != dv_q);
		sts.l2_err     = l2_diff && (!j_rd.ok || !ju_q.ok);
		sts.fin_err    = !ju_q.ok || !j_rd.ok || (ju_q.anc != j_rd.anc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clr) begin
			clr_q <= clr_q + NODE_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			type_q  <= req_type;
			u_q     <= NODE_BITS'(node);
			v_q     <= NODE_BITS'(other_node);
			u_inr_q <= (32'(node) < NODE_COUNT);
			v_inr_q <= (32'(other_node) < NODE_COUNT);
			w_q     <= WEIGHT_BITS'(weight);
			lo_q    <= '1;
			hi_q    <= '0;
			err_q   <= 1'b0;
			empty_q <= 1'b0;
			path_q  <= 1'b0;
			prev_q  <= '0;
		end
		if (ctl.a_rd || ctl.q_rd) begin
			du_q <= d_rd_a.dep;
			dv_q <= d_rd_b.dep;
			ua_q <= d_rd_a.att;
			va_q <= d_rd_b.att;
		end
		if (ctl.lvl_init) lvl_q <= LVL_TOP;
		else if (ctl.lvl_dec) lvl_q <= lvl_m1;
		if (ctl.a_wr0) begin
			prev_q <= '{ok: 1'b1, anc: v_q, mn: w_q, mx: w_q};
			lvl_q  <= LVL_BITS'(1);
		end
		if (ctl.a_root) begin
			prev_q <= '0;
			lvl_q  <= LVL_BITS'(1);
		end
		if (ctl.a_lwr) begin
			prev_q <= j_wdata;
			lvl_q  <= lvl_q + LVL_BITS'(1);
		end
		if (ctl.q_swap && du_q > dv_q) begin
			u_q  <= v_q;
			v_q  <= u_q;
			du_q <= dv_q;
			dv_q <= du_q;
		end
		if (ctl.l1_drd) ju_q <= j_rd;
		if (ctl.l1_upd && ju_q.ok && d_rd_b.dep >= du_q) begin
			lo_q <= wmin(lo_q, ju_q.mn);
			hi_q <= wmax(hi_q, ju_q.mx);
			v_q  <= ju_q.anc;
			dv_q <= d_rd_b.dep;
		end
		if (ctl.l2_rdv) ju_q <= j_rd;
		if (ctl.l2_upd && l2_diff && j_rd.ok && ju_q.ok) begin
			lo_q <= wmin(lo_q, wmin(j_rd.mn, ju_q.mn));
			hi_q <= wmax(hi_q, wmax(j_rd.mx, ju_q.mx));
			v_q  <= j_rd.anc;
			u_q  <= ju_q.anc;
		end
		if (ctl.fin) begin
			lo_q <= wmin(lo_q, wmin(j_rd.mn, ju_q.mn));
			hi_q <= wmax(hi_q, wmax(j_rd.mx, ju_q.mx));
		end
		if (ctl.set_err) err_q <= 1'b1;
		if (ctl.set_empty) empty_q <= 1'b1;
		if (ctl.set_ok_path) path_q <= 1'b1;
	end

	// ju_q holds the u entry in the second pass; l2_rdv registers it from the u read
	always_comb begin
		r_status = err_q ? ST_ERR : ST_OK;
		r_empty  = !err_q && empty_q && (type_q == REQ_QUERY);
		r_min    = (!err_q && path_q) ? 20'(lo_q) : '0;
		r_max    = (!err_q && path_q) ? 20'(hi_q) : '0;
	end
endmodule

// File: hdl/tree_path_min_max_query_top.sv
// ----------------------------------------------------------------------------
// tree_path_min_max_query_top
// Binary-lifting tree store answering path min/max edge weight queries.
// ----------------------------------------------------------------------------
// Usage: an input item with req_type 0 attaches node under other_node with
// weight (node equal to other_node makes a root); req_type 1 asks for the
// least and greatest edge weight on the path between node and other_node.
// Every item returns exactly one result item on the output channel.
// Items are handled one at a time. An attach does one ancestor-table read and
// one write per lift level on the single-port jump memory; an attach under a
// missing parent skips the lift levels and goes straight to the output. A
// query runs a depth-equalizing pass and then, if the nodes have not met, a
// joint pass, each level reading the jump memory. The block returns to idle
// before the next item is accepted.
// The result sits in an output register; while it waits there the next item
// is worked on and held in its last state until the register frees.
// After reset the depth memory, which carries the attached flags, is cleared
// with in_stall high; the jump memory is not cleared and its contents are
// only used for attached nodes.
// ----------------------------------------------------------------------------
module tree_path_min_max_query_top import tpq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [9:0]  node,
	input  logic [9:0]  other_node,
	input  logic [19:0] weight,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [19:0] path_min,
	output logic [19:0] path_max,
	output logic        empty_path
);
	ctl_t        ctl;
	sts_t        sts;
	logic        r_status, r_empty;
	logic [19:0] r_min, r_max;
	logic        out_free;

	assign out_free = !out_valid || !out_stall;

	tpq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_free(out_free), .sts(sts), .ctl(ctl));

	tpq_dp u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.req_type(req_type), .node(node), .other_node(other_node), .weight(weight),
		.r_status(r_status), .r_min(r_min), .r_max(r_max), .r_empty(r_empty));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			status     <= r_status;
			path_min   <= r_min;
			path_max   <= r_max;
			empty_path <= r_empty;
		end
	end
endmodule

// File: test/tb_tree_path_min_max_query_top.sv
// ----------------------------------------------------------------------------
// tb_tree_path_min_max_query_top
// Drives attach and path query items into the tree path min/max block with
// random gaps and output stalls, predicts every result with a local
// binary-lifting model and compares each result field by field in order.
// ----------------------------------------------------------------------------
module tb_tree_path_min_max_query_top;
	import tpq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        status;
		logic [19:0] path_min;
		logic [19:0] path_max;
		logic        empty_path;
	} path_answer_t;

	class path_scoreboard;
		bit          att [NODE_COUNT];
		int unsigned dep [NODE_COUNT];
		bit          jok [NODE_COUNT][LIFT_LEVELS];
		int unsigned janc[NODE_COUNT][LIFT_LEVELS];
		int unsigned jmn [NODE_COUNT][LIFT_LEVELS];
		int unsigned jmx [NODE_COUNT][LIFT_LEVELS];
		path_answer_t pending[$];
		int errors;

		function void attach(int unsigned u, int unsigned p, int unsigned w, output bit st);
			int unsigned a;
			st = ST_OK;
			if (u == p) begin
				dep[u] = 0;
				for (int i = 0; i < LIFT_LEVELS; i++) begin
					jok[u][i] = 0; janc[u][i] = 0; jmn[u][i] = 0; jmx[u][i] = 0;
				end
				att[u] = 1;
				return;
			end
			if (!att[p]) begin
				st = ST_ERR;
				return;
			end
			dep[u] = (dep[p] >= NODE_COUNT - 1) ? NODE_COUNT - 1 : dep[p] + 1;
			jok[u][0] = 1; janc[u][0] = p; jmn[u][0] = w; jmx[u][0] = w;
			for (int i = 1; i < LIFT_LEVELS; i++) begin
				if (jok[u][i-1]) begin
					a = janc[u][i-1];
					jok[u][i] = jok[a][i-1];
					janc[u][i] = janc[a][i-1];
					jmn[u][i] = (jmn[u][i-1] < jmn[a][i-1]) ? jmn[u][i-1] : jmn[a][i-1];
					jmx[u][i] = (jmx[u][i-1] > jmx[a][i-1]) ? jmx[u][i-1] : jmx[a][i-1];
				end else begin
					jok[u][i] = 0; janc[u][i] = 0;
					jmn[u][i] = jmn[u][i-1]; jmx[u][i] = jmx[u][i-1];
				end
			end
			att[u] = 1;
		endfunction

		function void lift(inout int unsigned lo, inout int unsigned hi, input int unsigned m,
				input int unsigned x);
			if (m < lo) lo = m;
			if (x > hi) hi = x;
		endfunction

		function path_answer_t query(int unsigned u, int unsigned v);
			path_answer_t r;
			int unsigned lo, hi, t;
			r = '0;
			lo = (1 << WEIGHT_BITS) - 1;
			hi = 0;
			if (!att[u] || !att[v]) begin
				r.status = ST_ERR;
				return r;
			end
			if (u == v) begin
				r.empty_path = 1;
				return r;
			end
			if (dep[u] > dep[v]) begin
				t = u; u = v; v = t;
			end
			for (int i = LIFT_LEVELS - 1; i >= 0; i--)
				if (jok[v][i] && dep[janc[v][i]] >= dep[u]) begin
					lift(lo, hi, jmn[v][i], jmx[v][i]);
					v = janc[v][i];
				end
			if (v != u) begin
				if (dep[v] != dep[u]) begin
					r.status = ST_ERR;
					return r;
				end
				for (int i = LIFT_LEVELS - 1; i >= 0; i--)
					if (jok[v][i] != jok[u][i] || (jok[v][i] && janc[v][i] != janc[u][i])) begin
						if (!jok[v][i] || !jok[u][i]) begin
							r.status = ST_ERR;
							return r;
						end
						lift(lo, hi, jmn[v][i], jmx[v][i]);
						lift(lo, hi, jmn[u][i], jmx[u][i]);
						v = janc[v][i];
						u = janc[u][i];
					end
				if (!jok[v][0] || !jok[u][0] || janc[v][0] != janc[u][0]) begin
					r.status = ST_ERR;
					return r;
				end
				lift(lo, hi, jmn[v][0], jmx[v][0]);
				lift(lo, hi, jmn[u][0], jmx[u][0]);
			end
			r.path_min = 20'(lo);
			r.path_max = 20'(hi);
			return r;
		endfunction

		function void note_item(bit kind, int unsigned a, int unsigned b, int unsigned w);
			path_answer_t r;
			bit st;
			if (kind == REQ_ATTACH) begin
				r = '0;
				attach(a, b, w, st);
				r.status = st;
			end else
				r = query(a, b);
			pending.push_back(r);
		endfunction

		function void check_result(path_answer_t got);
			path_answer_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.status !== exp_r.status) begin
				$display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
				errors++;
			end
			if (got.path_min !== exp_r.path_min) begin
				$display("%0t: path_min exp %0d got %0d", $time, exp_r.path_min, got.path_min);
				errors++;
			end
			if (got.path_max !== exp_r.path_max) begin
				$display("%0t: path_max exp %0d got %0d", $time, exp_r.path_max, got.path_max);
				errors++;
			end
			if (got.empty_path !== exp_r.empty_path) begin
				$display("%0t: empty_path exp %0d got %0d", $time, exp_r.empty_path,
					got.empty_path);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic        req_type = 0;
	logic [9:0]  node = 0;
	logic [9:0]  other_node = 0;
	logic [19:0] weight = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic        status;
	logic [19:0] path_min;
	logic [19:0] path_max;
	logic        empty_path;

	path_scoreboard board = new();
	bit          hold_out = 0;
	int unsigned tree_nodes[$];

	tree_path_min_max_query_top dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

	function int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(bit kind, int unsigned a, int unsigned b, int unsigned w);
		req_type   <= kind;
		node       <= 10'(a);
		other_node <= 10'(b);
		weight     <= 20'(w);
		in_valid   <= 1;
		do @(posedge clk); while (in_stall);
		board.note_item(kind, a, b, w);
		if (kind == REQ_ATTACH && a != b && board.att[b] || kind == REQ_ATTACH && a == b)
			tree_nodes.push_back(a);
	endtask

	task automatic idle_gap();
		int unsigned g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	function int unsigned known_node();
		if (tree_nodes.size() == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
		return tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
	endfunction

	task automatic random_item();
		int unsigned r, w;
		r = $urandom_range(0, 99);
		w = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 20'hFFFFF : 0)
			: $urandom_range(0, 20'hFFFFF);
		if (r < 40)
			send_item(REQ_ATTACH, $urandom_range(0, 1023), known_node(), w);
		else if (r < 43)
			send_item(REQ_ATTACH, $urandom_range(0, 1023), $urandom_range(0, 1023), w);
		else if (r < 45) begin
			r = $urandom_range(0, 1023);
			send_item(REQ_ATTACH, r, r, w);
		end else if (r < 48) begin
			r = known_node();
			send_item(REQ_QUERY, r, r, w);
		end else
			send_item(REQ_QUERY, known_node(), known_node(), w);
	endtask

	// output side: random stalls, one long hold-off
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			board.check_result({status, path_min, path_max, empty_path});
		if (hold_out)
			out_stall <= 1;
		else if ($urandom_range(0, 99) < 8)
			out_stall <= 1;
		else
			out_stall <= ($urandom_range(0, 99) < 25) && ($urandom_range(0, 9) == 0);
	end

	initial begin
		int unsigned wait_cnt;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, roots, chains, errors, same node
		send_item(REQ_QUERY, 0, 0, 0);
		send_item(REQ_ATTACH, 5, 1023, 20'hFFFFF);
		send_item(REQ_ATTACH, 0, 0, 20'hABCDE);
		send_item(REQ_ATTACH, 1023, 0, 20'hFFFFF);
		send_item(REQ_ATTACH, 512, 1023, 0);
		send_item(REQ_ATTACH, 341, 512, 20'h55555);
		send_item(REQ_ATTACH, 682, 0, 20'hAAAAA);
		send_item(REQ_QUERY, 341, 682, 0);
		send_item(REQ_QUERY, 682, 341, 20'hFFFFF);
		send_item(REQ_QUERY, 1023, 0, 0);
		send_item(REQ_QUERY, 512, 512, 0);
		send_item(REQ_QUERY, 5, 0, 0);
		send_item(REQ_ATTACH, 900, 900, 0);
		send_item(REQ_QUERY, 900, 341, 0);
		send_item(REQ_ATTACH, 512, 682, 20'h12345);
		send_item(REQ_QUERY, 341, 1023, 0);
		send_item(REQ_QUERY, 512, 0, 0);
		// long chain for deep lifts
		for (int i = 0; i < 40; i++)
			send_item(REQ_ATTACH, 100 + i, (i == 0) ? 0 : 99 + i, $urandom_range(0, 20'hFFFFF));
		send_item(REQ_QUERY, 139, 682, 0);
		send_item(REQ_QUERY, 100, 139, 0);
		// sender pauses until everything drained
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		// long receiver hold-off while items keep coming
		hold_out = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_out = 0;
			end
			for (int i = 0; i < 20; i++) random_item();
		join
		for (int n = 0; n < 1800; n++) begin
			random_item();
			if ($urandom_range(0, 3) == 0) idle_gap();
		end
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		wait_cnt = 0;
		while (wait_cnt < 100) begin
			@(posedge clk);
			wait_cnt++;
		end
		if (board.errors == 0 && board.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
